/* rtl/core/uad_pkg.sv */
// Shared types, codes and arithmetic constants of the upwind advection-diffusion step block.
package uad_pkg;

   localparam int UAD_CELLS   = 64;
   localparam int UAD_SPECIES = 4;

   localparam int MUL_W = 49;
   localparam int DIV_W = 64;
   localparam int Q_W   = 48;

   typedef logic [2:0] op_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] csr_index_type;

   localparam op_type OP_WRITE = 3'd0;
   localparam op_type OP_READ  = 3'd1;
   localparam op_type OP_LOAD  = 3'd2;
   localparam op_type OP_STEP  = 3'd3;
   localparam op_type OP_AVG   = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_SKIP  = 2'd2;

   localparam csr_index_type CSR_CELL_WIDTH = 2'd0;
   localparam csr_index_type CSR_AREA       = 2'd1;
   localparam csr_index_type CSR_ACTIVE     = 2'd2;

   localparam logic [Q_W-1:0] Q_CAP    = 48'h8000_0000_0000;
   localparam logic [30:0]    UMAG_MAX = 31'h7FFF_FFFF;

endpackage

/* rtl/core/upwind_advection_diffusion_step.sv */
// Top level: concentration store, species tables and the operation sequencer.
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tuser operation, tdata cell..density
//  rsp      out  rsp_tvalid/tready    tdata result_value, status
//  csr      in   csr_valid/ready      csr_index, csr_data
// A time step uses the serial divider for its quotients and three multiplies per cell.
// Reset is synchronous; the store reads as zero until each entry is written.
// One request is worked at a time; a new request is taken while a result waits.
module upwind_advection_diffusion_step import uad_pkg::*; #(
   parameter int CELLS   = UAD_CELLS,
   parameter int SPECIES = UAD_SPECIES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [2:0]    req_tuser,   // operation
   // cell_index, species_index, value, diffusivity, left_boundary,
   // right_boundary, time_step, flow_rate, density
   input  logic [231:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata,   // result_value, status, zero pad
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_data
);

   localparam int DEPTH = CELLS * SPECIES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(CELLS + 1);
   localparam int SW    = (SPECIES > 1) ? $clog2(SPECIES) : 1;
   localparam int SUM_W = 32 + NW;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RDW  = 4'd1;
   localparam logic [3:0] S_AVGR = 4'd2;
   localparam logic [3:0] S_AVGA = 4'd3;
   localparam logic [3:0] S_UDEN = 4'd4;
   localparam logic [3:0] S_UDIV = 4'd5;
   localparam logic [3:0] S_DIVW = 4'd6;
   localparam logic [3:0] S_LD0  = 4'd7;
   localparam logic [3:0] S_LDC  = 4'd8;
   localparam logic [3:0] S_NEXT = 4'd9;
   localparam logic [3:0] S_GETR = 4'd10;
   localparam logic [3:0] S_MST  = 4'd11;
   localparam logic [3:0] S_MUL  = 4'd12;
   localparam logic [3:0] S_FIN  = 4'd13;
   localparam logic [3:0] S_KST  = 4'd14;

   localparam logic [1:0] DT_U   = 2'd0;
   localparam logic [1:0] DT_R   = 2'd1;
   localparam logic [1:0] DT_K   = 2'd2;
   localparam logic [1:0] DT_AVG = 2'd3;

   localparam logic [1:0] MS_ADV = 2'd0;
   localparam logic [1:0] MS_DIF = 2'd1;
   localparam logic [1:0] MS_UPD = 2'd2;

   function automatic logic [AW-1:0] addr_of(input int c, input int s);
      return AW'(c * SPECIES + s);
   endfunction

   op_type      op;
   logic [5:0]  f_cell;
   logic [1:0]  f_sp;
   logic [31:0] f_value, f_diff, f_lb, f_rb, f_dt, f_flow, f_dens;

   assign op      = req_tuser;
   assign f_cell  = req_tdata[5:0];
   assign f_sp    = req_tdata[7:6];
   assign f_value = req_tdata[39:8];
   assign f_diff  = req_tdata[71:40];
   assign f_lb    = req_tdata[103:72];
   assign f_rb    = req_tdata[135:104];
   assign f_dt    = req_tdata[167:136];
   assign f_flow  = req_tdata[199:168];
   assign f_dens  = req_tdata[231:200];

   logic [31:0] cw_ff, area_ff;
   logic [6:0]  act_ff;
   logic [31:0] diff_tab_ff [SPECIES];
   logic [31:0] lb_tab_ff   [SPECIES];
   logic [31:0] rb_tab_ff   [SPECIES];

   logic [3:0]  state_ff, state_in;
   logic [1:0]  tag_ff, sel_ff;
   logic [SW-1:0] sp_ff;
   logic [NW-1:0] i_ff;
   logic [31:0] dt_ff, flow_ff, dens_ff;
   logic [63:0] den_ff;
   logic [30:0] umag_ff;
   logic [Q_W-1:0] r_ff, k_ff;
   logic [31:0] left_ff, right_ff, c_ff;
   logic signed [48:0] p1_ff;
   logic        net_neg_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [31:0] res_ff;
   status_type  st_ff;
   logic        rsp_tvalid_ff;
   logic [39:0] rsp_tdata_ff;

   logic [31:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [31:0] rd_data_ff;
   logic        rd_vld_ff;
   logic [31:0] rdval;

   logic          mem_re, mem_we;
   logic [AW-1:0] mem_raddr, mem_waddr;
   logic [31:0]   mem_wdata;

   logic             div_start, div_done;
   logic [DIV_W-1:0] div_num, div_den, div_quo;
   logic             mul_start, mul_done;
   logic [MUL_W-1:0] mul_a, mul_b;
   logic [Q_W-1:0]   mul_p;

   logic [NW-1:0] n;
   logic          req_fire, sp_ok, cell_ok, dens_bad, last_cell, out_free;
   logic [31:0]   dx, area, fmag, up;
   logic signed [33:0] d1;
   logic signed [34:0] d2;
   logic [33:0]   mag1;
   logic [34:0]   mag2;
   logic          msgn;
   logic signed [48:0] p_s;
   logic signed [49:0] net, nv;
   logic [49:0]   net_mag;
   logic [31:0]   nv_clamp;
   logic [Q_W-1:0] div_cap;
   logic [30:0]   div_umag;

   always_comb begin
      if (act_ff == 7'd0) begin
         n = NW'(1);
      end else if (int'(act_ff) > CELLS) begin
         n = NW'(CELLS);
      end else begin
         n = NW'(act_ff);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign sp_ok      = int'(f_sp) < SPECIES;
   assign cell_ok    = sp_ok && (int'(f_cell) < int'(n));
   assign dens_bad   = f_dens[31] || (f_dens == 32'd0);
   assign last_cell  = (int'(i_ff) + 1) >= int'(n);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign dx   = (cw_ff == 32'd0) ? 32'd1 : cw_ff;
   assign area = (area_ff == 32'd0) ? 32'd1 : area_ff;
   assign fmag = flow_ff[31] ? (32'd0 - flow_ff) : flow_ff;
   assign up   = flow_ff[31] ? right_ff : left_ff;
   assign rdval = rd_vld_ff ? rd_data_ff : 32'd0;

   assign d1 = $signed({2'b00, up}) - $signed({2'b00, c_ff});
   assign d2 = $signed({3'b000, left_ff}) + $signed({3'b000, right_ff})
             - $signed({2'b00, c_ff, 1'b0});
   assign mag1 = d1[33] ? 34'(-d1) : 34'(d1);
   assign mag2 = d2[34] ? 35'(-d2) : 35'(d2);

   always_comb begin
      unique case (sel_ff)
         MS_ADV:  msgn = d1[33];
         MS_DIF:  msgn = d2[34];
         default: msgn = net_neg_ff;
      endcase
   end

   assign p_s     = msgn ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
   assign net     = $signed({p1_ff[48], p1_ff}) + $signed({p_s[48], p_s});
   assign net_mag = net[49] ? 50'(-net) : 50'(net);
   assign nv      = $signed({18'd0, c_ff}) + $signed({p_s[48], p_s});

   always_comb begin
      if (nv[49]) begin
         nv_clamp = 32'd0;
      end else if (nv[49:32] != 18'd0) begin
         nv_clamp = 32'hFFFF_FFFF;
      end else begin
         nv_clamp = nv[31:0];
      end
   end

   assign div_cap  = (div_quo > 64'(Q_CAP)) ? Q_CAP : div_quo[Q_W-1:0];
   assign div_umag = (div_quo > 64'(UMAG_MAX)) ? UMAG_MAX : div_quo[30:0];

   always_comb begin
      state_in  = state_ff;
      mem_re    = 1'b0;
      mem_raddr = '0;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_FIN;
               unique case (op)
                  OP_WRITE: begin
                     if (cell_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = addr_of(int'(f_cell), int'(f_sp));
                        mem_wdata = f_value;
                     end
                  end
                  OP_READ: begin
                     if (cell_ok) begin
                        mem_re    = 1'b1;
                        mem_raddr = addr_of(int'(f_cell), int'(f_sp));
                        state_in  = S_RDW;
                     end
                  end
                  OP_STEP: begin
                     if (!dens_bad) begin
                        state_in = S_UDEN;
                     end
                  end
                  OP_AVG: begin
                     if (sp_ok) begin
                        state_in = S_AVGR;
                     end
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_RDW: state_in = S_FIN;
         S_AVGR: begin
            mem_re    = 1'b1;
            mem_raddr = addr_of(int'(i_ff), int'(sp_ff));
            state_in  = S_AVGA;
         end
         S_AVGA: begin
            if (last_cell) begin
               div_start = 1'b1;
               div_num   = DIV_W'(sum_ff + SUM_W'(rdval));
               div_den   = DIV_W'(n);
               state_in  = S_DIVW;
            end else begin
               state_in = S_AVGR;
            end
         end
         S_UDEN: state_in = S_UDIV;
         S_UDIV: begin
            div_start = 1'b1;
            div_num   = {fmag, 32'd0};
            div_den   = den_ff;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               unique case (tag_ff)
                  DT_U: begin
                     div_start = 1'b1;
                     div_num   = DIV_W'({dt_ff, 16'd0});
                     div_den   = DIV_W'(dx);
                  end
                  DT_R:    state_in = S_KST;
                  DT_K:    state_in = S_LD0;
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_KST: begin
            div_start = 1'b1;
            div_num   = DIV_W'({diff_tab_ff[sp_ff], 16'd0});
            div_den   = DIV_W'(dx);
            state_in  = S_DIVW;
         end
         S_LD0: begin
            mem_re    = 1'b1;
            mem_raddr = addr_of(0, int'(sp_ff));
            state_in  = S_LDC;
         end
         S_LDC: state_in = S_NEXT;
         S_NEXT: begin
            if (last_cell) begin
               state_in = S_MST;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = addr_of(int'(i_ff) + 1, int'(sp_ff));
               state_in  = S_GETR;
            end
         end
         S_GETR: state_in = S_MST;
         S_MST: begin
            mul_start = 1'b1;
            mul_a     = MUL_W'(umag_ff);
            mul_b     = MUL_W'(mag1);
            state_in  = S_MUL;
         end
         S_MUL: begin
            if (mul_done) begin
               unique case (sel_ff)
                  MS_ADV: begin
                     mul_start = 1'b1;
                     mul_a     = MUL_W'(k_ff);
                     mul_b     = MUL_W'(mag2);
                  end
                  MS_DIF: begin
                     mul_start = 1'b1;
                     mul_a     = MUL_W'(r_ff);
                     mul_b     = net_mag[MUL_W-1:0];
                  end
                  default: begin
                     mem_we    = 1'b1;
                     mem_waddr = addr_of(int'(i_ff), int'(sp_ff));
                     mem_wdata = nv_clamp;
                     if (!last_cell) begin
                        state_in = S_NEXT;
                     end else if (int'(sp_ff) == SPECIES - 1) begin
                        state_in = S_FIN;
                     end else begin
                        state_in = S_KST;
                     end
                  end
               endcase
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
         rd_vld_ff  <= vld_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[mem_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff   <= 32'd65536;
         area_ff <= 32'd65536;
         act_ff  <= 7'd64;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CELL_WIDTH: cw_ff   <= csr_data;
            CSR_AREA:       area_ff <= csr_data;
            CSR_ACTIVE:     act_ff  <= csr_data[6:0];
            default:        act_ff  <= act_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SPECIES; s++) begin
            diff_tab_ff[s] <= '0;
            lb_tab_ff[s]   <= '0;
            rb_tab_ff[s]   <= '0;
         end
      end else if (req_fire && op == OP_LOAD && sp_ok) begin
         diff_tab_ff[SW'(f_sp)] <= f_diff;
         lb_tab_ff[SW'(f_sp)]   <= f_lb;
         rb_tab_ff[SW'(f_sp)]   <= f_rb;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_ff  <= 32'd0;
               sp_ff   <= (op == OP_STEP) ? '0 : SW'(f_sp);
               i_ff    <= '0;
               sum_ff  <= '0;
               dt_ff   <= f_dt;
               flow_ff <= f_flow;
               dens_ff <= f_dens;
               unique case (op)
                  OP_WRITE, OP_READ: st_ff <= cell_ok ? ST_OK : ST_RANGE;
                  OP_LOAD, OP_AVG:   st_ff <= sp_ok ? ST_OK : ST_RANGE;
                  OP_STEP:           st_ff <= dens_bad ? ST_SKIP : ST_OK;
                  default:           st_ff <= ST_OK;
               endcase
            end
         end
         S_RDW: res_ff <= rdval;
         S_AVGA: begin
            sum_ff <= sum_ff + SUM_W'(rdval);
            i_ff   <= i_ff + 1'b1;
            tag_ff <= DT_AVG;
         end
         S_UDEN: den_ff <= 64'(dens_ff) * 64'(area);
         S_UDIV: tag_ff <= DT_U;
         S_DIVW: begin
            if (div_done) begin
               unique case (tag_ff)
                  DT_U: begin
                     umag_ff <= div_umag;
                     tag_ff  <= DT_R;
                  end
                  DT_R:    r_ff   <= div_cap;
                  DT_K:    k_ff   <= div_cap;
                  default: res_ff <= div_quo[31:0];
               endcase
            end
         end
         S_KST: tag_ff <= DT_K;
         S_LD0: begin
            left_ff <= lb_tab_ff[sp_ff];
            i_ff    <= '0;
         end
         S_LDC: c_ff <= rdval;
         S_NEXT: begin
            if (last_cell) begin
               right_ff <= rb_tab_ff[sp_ff];
            end
         end
         S_GETR: right_ff <= rdval;
         S_MST: sel_ff <= MS_ADV;
         S_MUL: begin
            if (mul_done) begin
               unique case (sel_ff)
                  MS_ADV: begin
                     p1_ff  <= p_s;
                     sel_ff <= MS_DIF;
                  end
                  MS_DIF: begin
                     net_neg_ff <= net[49];
                     sel_ff     <= MS_UPD;
                  end
                  default: begin
                     left_ff <= c_ff;
                     c_ff    <= right_ff;
                     if (!last_cell) begin
                        i_ff <= i_ff + 1'b1;
                     end else begin
                        sp_ff <= sp_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         default: res_ff <= res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_FIN && out_free) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_tdata_ff  <= {6'd0, st_ff, res_ff};
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   uad_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   uad_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

`ifndef SYNTHESIS
   a_units_apart: assert property (@(posedge clock) disable iff (reset)
      !(mul_done && div_done)) else $error("divider and multiplier finished together");
   a_store_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_IDLE || state_ff == S_MUL))
      else $error("store written outside write or update");
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready) else $error("request taken while busy");
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && out_free) |=> (rsp_tvalid && state_ff == S_IDLE))
      else $error("result not presented");
`endif

endmodule

/* rtl/core/uad_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module uad_div import uad_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic             done,
   output logic [DIV_W-1:0] quo
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] num_ff, den_ff, rem_ff, quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DIV_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         num_ff  <= num;
         den_ff  <= den;
         rem_ff  <= '0;
         quo_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[DIV_W-2:0], 1'b0};
         if (fits) begin
            rem_ff <= DIV_W'(trial - {1'b0, den_ff});
         end else begin
            rem_ff <= trial[DIV_W-1:0];
         end
         quo_ff  <= {quo_ff[DIV_W-2:0], fits};
         cnt_ff  <= cnt_ff + 1'b1;
         busy_ff <= (int'(cnt_ff) != DIV_W - 1);
         done_ff <= (int'(cnt_ff) == DIV_W - 1);
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

/* rtl/core/uad_mul.sv */
// Four-phase partial-product multiplier with Q16.16 shift and saturation.
module uad_mul import uad_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MUL_W-1:0] a,
   input  logic [MUL_W-1:0] b,
   output logic             done,
   output logic [Q_W-1:0]   p
);

   localparam int HW = (MUL_W + 1) / 2;

   logic [2*HW-1:0] a_ff, b_ff;
   logic [4*HW-1:0] acc_ff;
   logic [1:0]      ph_ff;
   logic            busy_ff, done_ff;
   logic [HW-1:0]   a_half, b_half;
   logic [2*HW-1:0] pp;
   logic [4*HW-1:0] pp_sh;

   assign a_half = ph_ff[1] ? a_ff[2*HW-1:HW] : a_ff[HW-1:0];
   assign b_half = ph_ff[0] ? b_ff[2*HW-1:HW] : b_ff[HW-1:0];
   assign pp     = (2*HW)'(a_half) * (2*HW)'(b_half);
   assign pp_sh  = (4*HW)'(pp) << (HW * (int'(ph_ff[1]) + int'(ph_ff[0])));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         a_ff    <= (2*HW)'(a);
         b_ff    <= (2*HW)'(b);
         acc_ff  <= '0;
         ph_ff   <= '0;
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         acc_ff  <= acc_ff + pp_sh;
         ph_ff   <= ph_ff + 1'b1;
         busy_ff <= (ph_ff != 2'd3);
         done_ff <= (ph_ff == 2'd3);
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_comb begin
      if (acc_ff[4*HW-1:16] > (4*HW-16)'(Q_CAP)) begin
         p = Q_CAP;
      end else begin
         p = acc_ff[Q_W+15:16];
      end
   end

   assign done = done_ff;

endmodule

/* tb/upwind_advection_diffusion_step_tb.sv */
// Self-checking testbench of the upwind advection-diffusion step block: random and directed requests.
module upwind_advection_diffusion_step_tb import uad_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  NCELL     = UAD_CELLS;
   localparam int  NSPEC     = UAD_SPECIES;
   localparam int  LIMIT     = 5000000;
   localparam bit [63:0] SAT = 64'h0000_8000_0000_0000;

   typedef struct {
      op_type              op;
      bit [5:0]            cell_idx;
      bit [1:0]            sp;
      bit [31:0]           value;
      bit [31:0]           diff;
      bit [31:0]           lbnd;
      bit [31:0]           rbnd;
      bit [31:0]           dt;
      bit signed [31:0]    flow;
      bit signed [31:0]    dens;
   } request_type;

   typedef struct {
      bit [31:0]  value;
      status_type status;
   } answer_type;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [2:0]    req_tuser = '0;
   logic [231:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [39:0]   rsp_tdata;
   logic          csr_valid = 0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_CELL_WIDTH;
   logic [31:0]   csr_data = '0;

   upwind_advection_diffusion_step u_top (.*);

   always #2 clock = ~clock;

   bit [31:0] conc [NCELL*NSPEC];
   bit [31:0] diff_tab [NSPEC];
   bit [31:0] lbnd_tab [NSPEC];
   bit [31:0] rbnd_tab [NSPEC];
   bit [31:0] dx_reg, area_reg;
   bit [6:0]  active_reg;

   request_type  pending [$];
   request_type  current;
   answer_type   awaited [$];
   int        send_idle, recv_stall;
   int        mismatches, answers, steps_run, cycles;

   function automatic bit [63:0] mul_sat(bit [63:0] a, bit [63:0] b);
      bit [127:0] p;
      p = (128'(a) * 128'(b)) >> 16;
      return (p > 128'(SAT)) ? SAT : p[63:0];
   endfunction

   function automatic bit [63:0] div_sat(bit [63:0] a, bit [63:0] b);
      bit [63:0] q;
      q = (a << 16) / b;
      return (q > SAT) ? SAT : q;
   endfunction

   function automatic longint signed_mul(bit [63:0] mag, longint x);
      bit [63:0] m;
      m = mul_sat(mag, (x < 0) ? 64'(-x) : 64'(x));
      return (x < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic int cells_in_use();
      if (active_reg == 0) return 1;
      if (active_reg > NCELL) return NCELL;
      return int'(active_reg);
   endfunction

   function automatic void advance_store(bit [31:0] dt, longint flow, longint dens);
      int n;
      bit [63:0] dx, area, fmag, umag, ratio, kd;
      longint left, right, c, up, net, nv;
      n = cells_in_use();
      dx = (dx_reg == 0) ? 64'd1 : 64'(dx_reg);
      area = (area_reg == 0) ? 64'd1 : 64'(area_reg);
      fmag = (flow < 0) ? 64'(-flow) : 64'(flow);
      umag = (fmag << 32) / (64'(dens) * area);
      if (umag > 64'h7FFF_FFFF) umag = 64'h7FFF_FFFF;
      ratio = div_sat(64'(dt), dx);
      for (int s = 0; s < NSPEC; s++) begin
         kd = div_sat(64'(diff_tab[s]), dx);
         left = lbnd_tab[s];
         for (int i = 0; i < n; i++) begin
            c = conc[i*NSPEC+s];
            right = (i + 1 < n) ? longint'(conc[(i+1)*NSPEC+s]) : longint'(rbnd_tab[s]);
            up = (flow >= 0) ? left : right;
            net = signed_mul(umag, up - c) + signed_mul(kd, left + right - 2*c);
            nv = c + signed_mul(ratio, net);
            if (nv < 0) nv = 0;
            if (nv > 64'hFFFF_FFFF) nv = 64'hFFFF_FFFF;
            conc[i*NSPEC+s] = nv[31:0];
            left = c;
         end
      end
   endfunction

   function automatic answer_type apply_request(request_type r);
      answer_type a;
      int n;
      bit [63:0] sum;
      a.value = 0;
      a.status = ST_OK;
      n = cells_in_use();
      unique case (r.op)
         OP_WRITE, OP_READ: begin
            if (r.cell_idx >= n) a.status = ST_RANGE;
            else if (r.op == OP_WRITE) conc[r.cell_idx*NSPEC+r.sp] = r.value;
            else a.value = conc[r.cell_idx*NSPEC+r.sp];
         end
         OP_LOAD: begin
            diff_tab[r.sp] = r.diff;
            lbnd_tab[r.sp] = r.lbnd;
            rbnd_tab[r.sp] = r.rbnd;
         end
         OP_STEP: begin
            if (r.dens <= 0) a.status = ST_SKIP;
            else begin
               advance_store(r.dt, longint'(r.flow), longint'(r.dens));
               steps_run++;
            end
         end
         OP_AVG: begin
            sum = 0;
            for (int i = 0; i < n; i++) sum += conc[i*NSPEC+r.sp];
            a.value = 32'(sum / n);
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
      $display("mismatch on response %0d: %s got %h expected %h", answers, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) awaited.push_back(apply_request(current));
         if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
            current = pending.pop_front();
            req_tvalid <= 1;
            req_tuser <= current.op;
            req_tdata <= {current.dens, current.flow, current.dt, current.rbnd, current.lbnd,
                          current.diff, current.value, current.sp, current.cell_idx};
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata[31:0], 0);
            end else begin
               want = awaited.pop_front();
               if (rsp_tdata[31:0] != want.value)
                  report_mismatch("result_value", rsp_tdata[31:0], want.value);
               if (rsp_tdata[33:32] != want.status)
                  report_mismatch("status", 32'(rsp_tdata[33:32]), 32'(want.status));
            end
            answers++;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("upwind_advection_diffusion_step_tb failed");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, bit [31:0] data);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      unique case (idx)
         CSR_CELL_WIDTH: dx_reg = data;
         CSR_AREA:       area_reg = data;
         default:        active_reg = data[6:0];
      endcase
      csr_valid <= 0;
   endtask

   function automatic request_type blank(op_type op);
      request_type r;
      r = '{op: op, cell_idx: 0, sp: 0, value: 0, diff: 0, lbnd: 0, rbnd: 0, dt: 0,
            flow: 0, dens: 32'sh0001_0000};
      return r;
   endfunction

   function automatic bit [31:0] rand_q();
      unique case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h0002_0000);
         2: return $urandom_range(32'h0000_1000);
         default: return $urandom_range(32'h0100_0000);
      endcase
   endfunction

   function automatic request_type random_request(int step_pct);
      request_type r;
      int roll, n;
      n = cells_in_use();
      roll = $urandom_range(99);
      r = blank(OP_WRITE);
      if (roll < step_pct) r.op = OP_STEP;
      else if (roll < 35) r.op = OP_WRITE;
      else if (roll < 65) r.op = OP_READ;
      else if (roll < 77) r.op = OP_LOAD;
      else if (roll < 94) r.op = OP_AVG;
      else r.op = op_type'($urandom_range(7, 5));
      r.cell_idx = ($urandom_range(9) < 8) ? 6'($urandom_range(n - 1)) : 6'($urandom);
      r.sp = 2'($urandom);
      r.value = rand_q();
      r.diff = rand_q();
      r.lbnd = rand_q();
      r.rbnd = rand_q();
      r.dt = rand_q();
      r.flow = ($urandom_range(3) == 0) ? $urandom : $signed(32'($urandom_range(32'h0004_0000)))
               - 32'sh0002_0000;
      r.dens = ($urandom_range(4) == 0) ? $urandom : {1'b0, 31'($urandom_range(32'h0008_0000))};
      return r;
   endfunction

   task automatic drain();
      while (pending.size() > 0 || req_tvalid || awaited.size() > 0) @(negedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      request_type r;
      dx_reg = 65536;
      area_reg = 65536;
      active_reg = 64;
      send_idle = 0;
      recv_stall = 0;
      repeat (3) @(posedge clock);
      reset <= 0;

      write_csr(CSR_CELL_WIDTH, 32'h0001_0000);
      write_csr(CSR_AREA, 32'h0001_0000);
      write_csr(CSR_ACTIVE, 32'd8);

      r = blank(OP_WRITE); r.cell_idx = 0; r.value = 32'hFFFF_FFFF; pending.push_back(r);
      r = blank(OP_WRITE); r.cell_idx = 7; r.sp = 3; r.value = 32'h0; pending.push_back(r);
      r = blank(OP_WRITE); r.cell_idx = 3; r.sp = 1; r.value = 32'h0005_8000;
      pending.push_back(r);
      r = blank(OP_WRITE); r.cell_idx = 63; r.value = 32'h1234; pending.push_back(r);
      r = blank(OP_READ); r.cell_idx = 0; pending.push_back(r);
      r = blank(OP_READ); r.cell_idx = 8; r.sp = 2; pending.push_back(r);
      r = blank(OP_READ); r.cell_idx = 3; r.sp = 1; pending.push_back(r);
      r = blank(OP_LOAD); r.sp = 0; r.diff = 32'h0000_8000; r.lbnd = 32'hFFFF_FFFF;
      r.rbnd = 32'h0; pending.push_back(r);
      r = blank(OP_LOAD); r.sp = 3; r.diff = 32'hFFFF_FFFF; r.lbnd = 32'h0001_0000;
      r.rbnd = 32'hFFFF_FFFF; pending.push_back(r);
      r = blank(OP_LOAD); r.sp = 1; r.diff = 0; r.lbnd = 32'h0002_0000;
      r.rbnd = 32'h0003_0000; pending.push_back(r);
      r = blank(OP_STEP); r.dens = 0; r.dt = 32'h0000_1000; pending.push_back(r);
      r = blank(OP_STEP); r.dens = 32'sh8000_0000; pending.push_back(r);
      r = blank(OP_STEP); r.dt = 32'h0000_0800; r.flow = 32'sh0000_4000; pending.push_back(r);
      r = blank(OP_STEP); r.dt = 32'h0000_0800; r.flow = -32'sh0000_4000; pending.push_back(r);
      r = blank(OP_STEP); r.dt = 32'hFFFF_FFFF; r.flow = 32'sh8000_0000; r.dens = 1;
      pending.push_back(r);
      r = blank(OP_STEP); r.dt = 32'h0000_0100; r.flow = 32'sh7FFF_FFFF;
      r.dens = 32'sh7FFF_FFFF; pending.push_back(r);
      r = blank(OP_AVG); r.sp = 0; pending.push_back(r);
      r = blank(OP_AVG); r.sp = 3; pending.push_back(r);
      for (int k = 5; k < 8; k++) begin
         r = blank(op_type'(k)); r.cell_idx = 63; pending.push_back(r);
      end
      for (int k = 0; k < 285; k++) pending.push_back(random_request(8));
      drain();

      send_idle = 52;
      write_csr(CSR_CELL_WIDTH, 32'h0);
      write_csr(CSR_AREA, 32'hFFFF_FFFF);
      write_csr(CSR_ACTIVE, 32'd0);
      for (int k = 0; k < 285; k++) pending.push_back(random_request(8));
      drain();

      send_idle = 0;
      recv_stall = 52;
      write_csr(CSR_ACTIVE, 32'd64);
      write_csr(CSR_CELL_WIDTH, 32'hFFFF_FFFF);
      write_csr(CSR_AREA, 32'h0);
      for (int k = 0; k < 140; k++) pending.push_back(random_request(2));
      drain();
      write_csr(CSR_ACTIVE, 32'd127);
      for (int k = 0; k < 140; k++) pending.push_back(random_request(2));
      drain();

      send_idle = 11;
      recv_stall = 11;
      write_csr(CSR_CELL_WIDTH, 32'h0000_8000);
      write_csr(CSR_AREA, 32'h0002_0000);
      write_csr(CSR_ACTIVE, 32'd16);
      for (int k = 0; k < 285; k++) pending.push_back(random_request(8));
      drain();

      $display("checked %0d responses over four idle/stall phases, %0d time steps applied",
               answers, steps_run);
      $display("register settings covered zero, unit and full-scale width, area and cell count");
      if (mismatches == 0) begin
         $display("upwind_advection_diffusion_step_tb passed");
      end else begin
         $display("upwind_advection_diffusion_step_tb failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/uad_pkg.sv
rtl/core/uad_div.sv
rtl/core/uad_mul.sv
rtl/core/upwind_advection_diffusion_step.sv
tb/upwind_advection_diffusion_step_tb.sv
